// ===== src/linear_camera_ray_generator_top_defines.svh =====
// Assertion macros for the linear camera ray generator checks
`ifndef LINEAR_CAMERA_RAY_GENERATOR_TOP_DEFINES_SVH
`define LINEAR_CAMERA_RAY_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LCRG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcrg check failed");

// next-cycle implication, checked outside reset
`define LCRG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcrg check failed");

`endif

// ===== src/lcrg_pkg.sv =====
// Shared types, constants and helpers of the linear camera ray generator
package lcrg_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int INDEX_BITS    = 12;
	localparam int ADDR_W        = 6;
	localparam int SAT_W         = 66;
	localparam int QUO_BITS      = 31;

	typedef enum logic [2:0] {
		REG_RAY0_DIR = 3'd0,
		REG_RAY0_ORG = 3'd1,
		REG_RAY1_DIR = 3'd2,
		REG_RAY1_ORG = 3'd3,
		REG_RAY2_DIR = 3'd4,
		REG_RAY2_ORG = 3'd5,
		REG_PLANE    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] pixel_column;
		logic [INDEX_BITS-1:0] pixel_row;
	} pix_t;

	typedef struct packed {
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic               degenerate;
	} ray_t;

	// camera registers, one 32-bit word per ray and axis
	typedef struct packed {
		logic [2:0][31:0]   dir_x;
		logic [2:0][31:0]   dir_y;
		logic [2:0][31:0]   org_x;
		logic [2:0][31:0]   org_y;
		logic signed [31:0] plane;
	} cfg_t;

	typedef struct packed {
		logic signed [63:0] num_a;
		logic signed [63:0] num_b;
		logic signed [63:0] den;
	} geom_t;

	typedef struct packed {
		logic signed [31:0] alpha;
		logic signed [31:0] beta;
		logic               deg;
	} wgt_t;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		if (v[SAT_W-1:31] == '0 || v[SAT_W-1:31] == '1) begin
			return v[31:0];
		end else if (v[SAT_W-1]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7fff_ffff;
		end
	endfunction

endpackage

// ===== src/lcrg_cfg.sv =====
// APB register file holding the camera definition
module lcrg_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lcrg_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	output lcrg_pkg::cfg_t              cfg
);
	import lcrg_pkg::*;

	logic [63:0]        ray_q [6];
	logic signed [31:0] plane_q;
	reg_idx_t           idx;
	logic               wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) ray_q[i] <= '0;
			plane_q <= 32'sd65536;
		end else if (wr) begin
			case (idx)
				REG_RAY0_DIR: ray_q[0] <= pwdata;
				REG_RAY0_ORG: ray_q[1] <= pwdata;
				REG_RAY1_DIR: ray_q[2] <= pwdata;
				REG_RAY1_ORG: ray_q[3] <= pwdata;
				REG_RAY2_DIR: ray_q[4] <= pwdata;
				REG_RAY2_ORG: ray_q[5] <= pwdata;
				REG_PLANE:    plane_q  <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RAY0_DIR: prdata = ray_q[0];
			REG_RAY0_ORG: prdata = ray_q[1];
			REG_RAY1_DIR: prdata = ray_q[2];
			REG_RAY1_ORG: prdata = ray_q[3];
			REG_RAY2_DIR: prdata = ray_q[4];
			REG_RAY2_ORG: prdata = ray_q[5];
			REG_PLANE:    prdata = {32'd0, plane_q};
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cfg.dir_x[i] = ray_q[2*i][31:0];
			cfg.dir_y[i] = ray_q[2*i][63:32];
			cfg.org_x[i] = ray_q[2*i+1][31:0];
			cfg.org_y[i] = ray_q[2*i+1][63:32];
		end
		cfg.plane = plane_q;
	end

endmodule

// ===== src/lcrg_geom.sv =====
// Generator points, edge differences and the three determinants
module lcrg_geom #(
	parameter int FRAC_BITS = lcrg_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lcrg_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  lcrg_pkg::pix_t  pix,
	output logic            out_valid,
	input  logic            out_ready,
	output lcrg_pkg::geom_t geom
);
	import lcrg_pkg::*;

	localparam int NS = 5;
	localparam int XW = (INDEX_BITS + FRAC_BITS > 32) ? INDEX_BITS + FRAC_BITS : 32;

	logic [NS-1:0] vld_q, en, vld_in;

	logic signed [63:0] pdx_s1 [3], pdy_s1 [3];
	logic signed [31:0] px_s1, py_s1;
	logic signed [31:0] ptx_s2 [3], pty_s2 [3];
	logic signed [31:0] px_s2, py_s2;
	// edge vectors from point 0: to point 1, to point 2, to the pixel
	logic signed [31:0] d1x_s3, d1y_s3, d2x_s3, d2y_s3, dpx_s3, dpy_s3;
	logic signed [63:0] m_s4 [6];
	logic signed [63:0] na_s5, nb_s5, den_s5;
	logic [XW-1:0]      shx, shy;

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
	end
	assign vld_in   = {vld_q[NS-2:0], in_valid};
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) if (en[k]) vld_q[k] <= vld_in[k];
		end
	end

	assign shx = XW'(pix.pixel_column) << FRAC_BITS;
	assign shy = XW'(pix.pixel_row) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				pdx_s1[i] <= cfg.plane * $signed(cfg.dir_x[i]);
				pdy_s1[i] <= cfg.plane * $signed(cfg.dir_y[i]);
			end
			px_s1 <= (shx > XW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(shx[31:0]);
			py_s1 <= (shy > XW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(shy[31:0]);
		end
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				ptx_s2[i] <= sat32(SAT_W'($signed(cfg.org_x[i]))
					+ SAT_W'(pdx_s1[i] >>> FRAC_BITS));
				pty_s2[i] <= sat32(SAT_W'($signed(cfg.org_y[i]))
					+ SAT_W'(pdy_s1[i] >>> FRAC_BITS));
			end
			px_s2 <= px_s1;
			py_s2 <= py_s1;
		end
		if (en[2]) begin
			d1x_s3 <= sat32(SAT_W'(ptx_s2[1]) - SAT_W'(ptx_s2[0]));
			d1y_s3 <= sat32(SAT_W'(pty_s2[1]) - SAT_W'(pty_s2[0]));
			d2x_s3 <= sat32(SAT_W'(ptx_s2[2]) - SAT_W'(ptx_s2[0]));
			d2y_s3 <= sat32(SAT_W'(pty_s2[2]) - SAT_W'(pty_s2[0]));
			dpx_s3 <= sat32(SAT_W'(px_s2) - SAT_W'(ptx_s2[0]));
			dpy_s3 <= sat32(SAT_W'(py_s2) - SAT_W'(pty_s2[0]));
		end
		if (en[3]) begin
			m_s4[0] <= d1x_s3 * d2y_s3;
			m_s4[1] <= d2x_s3 * d1y_s3;
			m_s4[2] <= dpx_s3 * d2y_s3;
			m_s4[3] <= d2x_s3 * dpy_s3;
			m_s4[4] <= d1x_s3 * dpy_s3;
			m_s4[5] <= dpx_s3 * d1y_s3;
		end
		if (en[4]) begin
			den_s5 <= m_s4[0] - m_s4[1];
			na_s5  <= m_s4[2] - m_s4[3];
			nb_s5  <= m_s4[4] - m_s4[5];
		end
	end

	assign out_valid  = vld_q[NS-1];
	assign geom.num_a = na_s5;
	assign geom.num_b = nb_s5;
	assign geom.den   = den_s5;

endmodule

// ===== src/lcrg_div.sv =====
// Two-lane pipelined restoring divider giving saturated Q weights
module lcrg_div #(
	parameter int FRAC_BITS = lcrg_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lcrg_pkg::geom_t geom,
	output logic            out_valid,
	input  logic            out_ready,
	output lcrg_pkg::wgt_t  wgt
);
	import lcrg_pkg::*;

	localparam int QB = QUO_BITS;
	localparam int NS = QB + 3;
	localparam int SH = 31 - FRAC_BITS;

	logic [NS-1:0] vld_q, en, vld_in;

	logic [63:0] un_s1 [2];
	logic [63:0] ud_s1;
	logic        neg_s1 [2];
	logic        deg_s1;

	logic [63:0] rem_s2 [2];
	logic [30:0] nlo_s2 [2];
	logic        ovf_s2 [2], neg_s2 [2];
	logic [63:0] ud_s2;
	logic        deg_s2;

	// one quotient bit per step stage
	logic [63:0] rem_s3 [QB][2];
	logic [30:0] nlo_s3 [QB][2];
	logic [30:0] quo_s3 [QB][2];
	logic        ovf_s3 [QB][2], neg_s3 [QB][2];
	logic [63:0] ud_s3  [QB];
	logic        deg_s3 [QB];

	logic [63:0] rem_c [QB+1][2];
	logic [30:0] nlo_c [QB+1][2];
	logic [30:0] quo_c [QB+1][2];
	logic        ovf_c [QB+1][2], neg_c [QB+1][2];
	logic [63:0] ud_c  [QB+1];
	logic        deg_c [QB+1];

	logic signed [31:0] res_s4 [2];
	logic               deg_s4;

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
	end
	assign vld_in   = {vld_q[NS-2:0], in_valid};
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) if (en[k]) vld_q[k] <= vld_in[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			un_s1[0]  <= geom.num_a[63] ? 64'(-geom.num_a) : geom.num_a;
			un_s1[1]  <= geom.num_b[63] ? 64'(-geom.num_b) : geom.num_b;
			ud_s1     <= geom.den[63] ? 64'(-geom.den) : geom.den;
			neg_s1[0] <= geom.num_a[63] ^ geom.den[63];
			neg_s1[1] <= geom.num_b[63] ^ geom.den[63];
			deg_s1    <= (geom.den == '0);
		end
		if (en[1]) begin
			for (int l = 0; l < 2; l++) begin
				// quotient at or above 2^31 saturates
				ovf_s2[l] <= {{SH{1'b0}}, un_s1[l]} >= {ud_s1, {SH{1'b0}}};
				rem_s2[l] <= un_s1[l] >> SH;
				nlo_s2[l] <= 31'(un_s1[l] << FRAC_BITS);
				neg_s2[l] <= neg_s1[l];
			end
			ud_s2  <= ud_s1;
			deg_s2 <= deg_s1;
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rem_c[0][l] = rem_s2[l];
			nlo_c[0][l] = nlo_s2[l];
			quo_c[0][l] = '0;
			ovf_c[0][l] = ovf_s2[l];
			neg_c[0][l] = neg_s2[l];
		end
		ud_c[0]  = ud_s2;
		deg_c[0] = deg_s2;
		for (int k = 0; k < QB; k++) begin
			for (int l = 0; l < 2; l++) begin
				rem_c[k+1][l] = rem_s3[k][l];
				nlo_c[k+1][l] = nlo_s3[k][l];
				quo_c[k+1][l] = quo_s3[k][l];
				ovf_c[k+1][l] = ovf_s3[k][l];
				neg_c[k+1][l] = neg_s3[k][l];
			end
			ud_c[k+1]  = ud_s3[k];
			deg_c[k+1] = deg_s3[k];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [64:0] trial [2];
		logic        ge    [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l] = {rem_c[k][l], nlo_c[k][l][30]};
				ge[l]    = trial[l] >= {1'b0, ud_c[k]};
			end
		end

		always_ff @(posedge clk) begin
			if (en[k+2]) begin
				for (int l = 0; l < 2; l++) begin
					rem_s3[k][l] <= ge[l] ? 64'(trial[l] - {1'b0, ud_c[k]}) : trial[l][63:0];
					nlo_s3[k][l] <= {nlo_c[k][l][29:0], 1'b0};
					quo_s3[k][l] <= {quo_c[k][l][29:0], ge[l]};
					ovf_s3[k][l] <= ovf_c[k][l];
					neg_s3[k][l] <= neg_c[k][l];
				end
				ud_s3[k]  <= ud_c[k];
				deg_s3[k] <= deg_c[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			for (int l = 0; l < 2; l++) begin
				if (ovf_c[QB][l]) begin
					res_s4[l] <= neg_c[QB][l] ? 32'sh8000_0000 : 32'sh7fff_ffff;
				end else begin
					res_s4[l] <= neg_c[QB][l] ? -$signed({1'b0, quo_c[QB][l]})
						: $signed({1'b0, quo_c[QB][l]});
				end
			end
			deg_s4 <= deg_c[QB];
		end
	end

	assign out_valid = vld_q[NS-1];
	assign wgt.alpha = res_s4[0];
	assign wgt.beta  = res_s4[1];
	assign wgt.deg   = deg_s4;

endmodule

// ===== src/lcrg_blend.sv =====
// Third weight, weighted blend of the generator rays and output register
module lcrg_blend #(
	parameter int FRAC_BITS = lcrg_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lcrg_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  lcrg_pkg::wgt_t wgt,
	output logic           out_valid,
	input  logic           out_ready,
	output lcrg_pkg::ray_t ray
);
	import lcrg_pkg::*;

	localparam int NS = 3;

	logic [NS-1:0] vld_q, en, vld_in;

	logic signed [31:0] w_s1 [3];
	logic               deg_s1;
	logic signed [63:0] p_s2 [4][3];
	logic               deg_s2;
	logic signed [31:0] res_s3 [4];
	logic               deg_s3;

	// component c, weight w: alpha pairs ray1, beta ray2, the third weight ray0
	logic signed [31:0]      val [4][3];
	logic signed [SAT_W-1:0] sum [4];

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
	end
	assign vld_in   = {vld_q[NS-2:0], in_valid};
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) if (en[k]) vld_q[k] <= vld_in[k];
		end
	end

	always_comb begin
		for (int w = 0; w < 3; w++) begin
			val[0][w] = $signed(cfg.dir_x[(w + 1) % 3]);
			val[1][w] = $signed(cfg.dir_y[(w + 1) % 3]);
			val[2][w] = $signed(cfg.org_x[(w + 1) % 3]);
			val[3][w] = $signed(cfg.org_y[(w + 1) % 3]);
		end
		for (int c = 0; c < 4; c++) begin
			sum[c] = SAT_W'(p_s2[c][0]) + SAT_W'(p_s2[c][1]) + SAT_W'(p_s2[c][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			w_s1[0] <= wgt.alpha;
			w_s1[1] <= wgt.beta;
			w_s1[2] <= sat32((SAT_W'(1) << FRAC_BITS) - SAT_W'(wgt.alpha) - SAT_W'(wgt.beta));
			deg_s1  <= wgt.deg;
		end
		if (en[1]) begin
			for (int c = 0; c < 4; c++) begin
				for (int w = 0; w < 3; w++) p_s2[c][w] <= w_s1[w] * val[c][w];
			end
			deg_s2 <= deg_s1;
		end
		if (en[2]) begin
			for (int c = 0; c < 4; c++) begin
				res_s3[c] <= deg_s2 ? 32'sd0 : sat32(sum[c] >>> FRAC_BITS);
			end
			deg_s3 <= deg_s2;
		end
	end

	assign out_valid      = vld_q[NS-1];
	assign ray.dir_x      = res_s3[0];
	assign ray.dir_y      = res_s3[1];
	assign ray.start_x    = res_s3[2];
	assign ray.start_y    = res_s3[3];
	assign ray.degenerate = deg_s3;

endmodule

// ===== src/linear_camera_ray_generator_top.sv =====
// Top level of the linear camera ray generator
//
//   port group   role                   handshake
//   pix          pixel item in          pix_valid / pix_ready
//   ray          ray item out           ray_valid / ray_ready
//   apb          camera registers       psel / penable, pready tied high
//
// One pixel item is taken every cycle, the rate of the per-bit divider
// pipeline, unless output back-pressure has filled the stages; items pass
// 5 geometry stages, 34 divider stages (one quotient bit per step stage) and
// 3 blend stages, the last of which is the output register.
// Reset clears the valid bits and loads the camera registers (plane = 1.0).
// A stalled output holds the run of full stages behind it; bubbles still fill.
module linear_camera_ray_generator_top #(
	parameter int FRAC_BITS = lcrg_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  lcrg_pkg::pix_t              pix,
	output logic                        ray_valid,
	input  logic                        ray_ready,
	output lcrg_pkg::ray_t              ray,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lcrg_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);
	import lcrg_pkg::*;

	cfg_t  cfg;
	geom_t geom;
	wgt_t  wgt;
	logic  geom_valid, geom_ready, wgt_valid, wgt_ready;

	lcrg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lcrg_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.pix       (pix),
		.out_valid (geom_valid),
		.out_ready (geom_ready),
		.geom      (geom)
	);

	lcrg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (geom_valid),
		.in_ready  (geom_ready),
		.geom      (geom),
		.out_valid (wgt_valid),
		.out_ready (wgt_ready),
		.wgt       (wgt)
	);

	lcrg_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (wgt_valid),
		.in_ready  (wgt_ready),
		.wgt       (wgt),
		.out_valid (ray_valid),
		.out_ready (ray_ready),
		.ray       (ray)
	);

endmodule

// ===== src/lcrg_chk.sv =====
// Port-level checks of the ray generator, bound to the top level
`include "linear_camera_ray_generator_top_defines.svh"

module lcrg_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           pix_valid,
	input logic           pix_ready,
	input logic           ray_valid,
	input logic           ray_ready,
	input lcrg_pkg::ray_t ray,
	input logic           pready
);
	import lcrg_pkg::*;

	// a held result must not change
	`LCRG_ASSERT_NEXT(a_ray_hold, ray_valid && !ray_ready, ray_valid && $stable(ray))
	// a degenerate camera gives an all-zero ray
	`LCRG_ASSERT_NOW(a_deg_zero, ray_valid && ray.degenerate, ray.dir_x == 0 && ray.dir_y == 0 && ray.start_x == 0 && ray.start_y == 0)
	// input backpressure only while a result is waiting at the output
	`LCRG_ASSERT_NOW(a_stall_cause, !pix_ready, ray_valid && !ray_ready)
	`LCRG_ASSERT_NOW(a_pready, 1'b1, pready)

endmodule

bind linear_camera_ray_generator_top lcrg_chk u_lcrg_chk (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the linear camera ray generator: pixel items in, ray items out
`timescale 1ns / 100ps

module testbench;
	import lcrg_pkg::*;

	localparam int FB = 16;
	localparam int WATCHDOG_CYCLES = 6000;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	pix_t pix = '0;
	logic ray_valid;
	logic ray_ready = 1'b0;
	ray_t ray;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	linear_camera_ray_generator_top dut (.*);

	always #5 clk = ~clk;

	// local copy of the camera registers
	logic [63:0] cam_ray [6];
	logic signed [31:0] cam_plane;

	typedef struct {
		bit   typed;
		ray_t value;
	} typed_ray_t;

	ray_t pending_rays[$];
	typed_ray_t typed_rays[$];
	int errors = 0;
	int idle_cycles = 0;
	bit steady = 1'b0;       // no random gaps on either side
	bit hold_off = 1'b0;     // receiver long stall request

	function automatic logic signed [65:0] wide(input logic signed [63:0] v);
		return v;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fff_ffff;
		if (v < -66'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] area(input logic signed [31:0] ax, ay, bx, by,
			cx, cy);
		logic signed [31:0] ux, uy, vx, vy;
		logic signed [63:0] p1, p2;
		ux = clamp32(wide(bx) - wide(ax));
		uy = clamp32(wide(by) - wide(ay));
		vx = clamp32(wide(cx) - wide(ax));
		vy = clamp32(wide(cy) - wide(ay));
		p1 = ux * vy;
		p2 = vx * uy;
		return p1 - p2;
	endfunction

	function automatic logic signed [31:0] weight(input logic signed [63:0] n, d);
		bit neg;
		logic [63:0] un, ud, q, r, mag;
		logic signed [65:0] m;
		neg = (n < 0) != (d < 0);
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		q = un / ud;
		r = un % ud;
		if (q >= (64'd1 << (31 - FB))) begin
			mag = 64'd1 << 31;
		end else begin
			for (int i = 0; i < FB; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= ud) begin
					r = r - ud;
					q[0] = 1'b1;
				end
			end
			mag = q;
		end
		m = {2'b00, mag};
		return clamp32(neg ? -m : m);
	endfunction

	function automatic logic signed [31:0] mix(input logic signed [31:0] a, b, g, v1, v2, v0);
		logic signed [63:0] p0, p1, p2;
		logic signed [65:0] s;
		p0 = a * v1;
		p1 = b * v2;
		p2 = g * v0;
		s = wide(p0) + wide(p1) + wide(p2);
		return clamp32(s >>> FB);
	endfunction

	function automatic ray_t trace_ray(input pix_t p);
		logic signed [31:0] dx[3], dy[3], ox[3], oy[3], qx[3], qy[3], px, py;
		logic signed [31:0] al, be, ga;
		logic signed [63:0] m, den;
		ray_t r;
		for (int i = 0; i < 3; i++) begin
			dx[i] = cam_ray[2*i][31:0];
			dy[i] = cam_ray[2*i][63:32];
			ox[i] = cam_ray[2*i+1][31:0];
			oy[i] = cam_ray[2*i+1][63:32];
			m = cam_plane * dx[i];
			qx[i] = clamp32(wide(ox[i]) + wide(m >>> FB));
			m = cam_plane * dy[i];
			qy[i] = clamp32(wide(oy[i]) + wide(m >>> FB));
		end
		px = {4'd0, p.pixel_column, 16'd0};
		py = {4'd0, p.pixel_row, 16'd0};
		r = '0;
		den = area(qx[0], qy[0], qx[1], qy[1], qx[2], qy[2]);
		if (den == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		al = weight(area(qx[0], qy[0], px, py, qx[2], qy[2]), den);
		be = weight(area(qx[0], qy[0], qx[1], qy[1], px, py), den);
		ga = clamp32(66'sd65536 - wide(al) - wide(be));
		r.dir_x = mix(al, be, ga, dx[1], dx[2], dx[0]);
		r.dir_y = mix(al, be, ga, dy[1], dy[2], dy[0]);
		r.start_x = mix(al, be, ga, ox[1], ox[2], ox[0]);
		r.start_y = mix(al, be, ga, oy[1], oy[2], oy[0]);
		return r;
	endfunction

	// scoreboard and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_valid && pix_ready) begin
				typed_ray_t t;
				t = typed_rays.pop_front();
				pending_rays.push_back(t.typed ? t.value : trace_ray(pix));
			end
			if (ray_valid && ray_ready) begin
				if (pending_rays.size() == 0) begin
					$display("%0t: unexpected ray item %p", $time, ray);
					errors++;
				end else begin
					ray_t e;
					e = pending_rays.pop_front();
					if (e.dir_x !== ray.dir_x || e.dir_y !== ray.dir_y ||
							e.start_x !== ray.start_x || e.start_y !== ray.start_y ||
							e.degenerate !== ray.degenerate) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, ray);
						errors++;
					end
				end
			end
			if ((pix_valid && pix_ready) || (ray_valid && ray_ready) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG_CYCLES) begin
				$display("[linear_camera_ray_generator_top] ERROR");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				ray_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end else if (stall > 0) begin
				stall--;
				ray_ready <= 1'b0;
			end else begin
				ray_ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall = ($urandom_range(0, 20) == 0) ? $urandom_range(20, 80)
						: $urandom_range(1, 3);
			end
		end
	end

	task automatic reg_write(input int idx, input logic [63:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 8);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx < 6)
			cam_ray[idx] = v;
		else if (idx == REG_PLANE)
			cam_plane = v[31:0];
	endtask

	task automatic send_pixel(input pix_t p, input bit typed, input ray_t value);
		int gap;
		typed_ray_t t;
		t.typed = typed;
		t.value = value;
		typed_rays.push_back(t);
		pix_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (!(pix_valid && pix_ready));
		gap = 0;
		if (!steady && $urandom_range(0, 3) == 0)
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// called right at the edge that took the last item
	task automatic drain();
		pix_valid <= 1'b0;
		while (pending_rays.size() != 0 || typed_rays.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] xy(input logic signed [31:0] x, y);
		return {y, x};
	endfunction

	task automatic random_pixels(input int n, input bit full);
		pix_t p;
		ray_t none;
		none = '0;
		for (int i = 0; i < n; i++) begin
			if (full || $urandom_range(0, 3) == 0) begin
				p.pixel_column = $urandom;
				p.pixel_row = $urandom;
			end else begin
				p.pixel_column = $urandom_range(0, 40);
				p.pixel_row = $urandom_range(0, 40);
			end
			send_pixel(p, 1'b0, none);
		end
	endtask

	typedef struct {
		pix_t p;
		bit   typed;
		ray_t value;
	} row_t;

	initial begin
		row_t rows[$];
		ray_t degen;
		logic [63:0] v;
		for (int i = 0; i < 6; i++) cam_ray[i] = '0;
		cam_plane = 32'sd65536;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset every generator point is at zero: degenerate
		degen = '0;
		degen.degenerate = 1'b1;
		rows.push_back('{'{12'd0, 12'd0}, 1'b1, degen});
		rows.push_back('{'{12'd4095, 12'd4095}, 1'b1, degen});
		rows.push_back('{'{12'd4095, 12'd0}, 1'b1, degen});
		rows.push_back('{'{12'd0, 12'd4095}, 1'b1, degen});
		foreach (rows[i]) send_pixel(rows[i].p, rows[i].typed, rows[i].value);
		drain();

		// unit triangle camera, then pixels at and around the corners and far out
		reg_write(REG_RAY0_ORG, xy(0, 0));
		reg_write(REG_RAY1_ORG, xy(32'sd65536, 0));
		reg_write(REG_RAY2_ORG, xy(0, 32'sd65536));
		reg_write(REG_RAY0_DIR, xy(32'sd3 <<< 16, -32'sd2 <<< 16));
		reg_write(REG_RAY1_DIR, xy(-32'sd65536, 32'sd12345));
		reg_write(REG_RAY2_DIR, xy(32'sd7, 32'sd65536));
		reg_write(REG_PLANE, 0);
		rows.delete();
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 3; r++)
				rows.push_back('{'{12'(c), 12'(r)}, 1'b0, degen});
		rows.push_back('{'{12'd4095, 12'd4095}, 1'b0, degen});
		rows.push_back('{'{12'd4095, 12'd0}, 1'b0, degen});
		rows.push_back('{'{12'd0, 12'd4095}, 1'b0, degen});
		rows.push_back('{'{12'd2048, 12'd1}, 1'b0, degen});
		foreach (rows[i]) send_pixel(rows[i].p, rows[i].typed, rows[i].value);
		drain();

		// extremes of every register; index seven is unmapped and must be ignored
		reg_write(REG_RAY0_DIR, xy(32'sh7fff_ffff, 32'sh8000_0000));
		reg_write(REG_RAY0_ORG, xy(32'sh8000_0000, 32'sh8000_0000));
		reg_write(REG_RAY1_DIR, xy(32'sh8000_0000, 32'sh7fff_ffff));
		reg_write(REG_RAY1_ORG, xy(32'sh7fff_ffff, 32'sh8000_0000));
		reg_write(REG_RAY2_DIR, xy(32'sh7fff_ffff, 32'sh7fff_ffff));
		reg_write(REG_RAY2_ORG, xy(32'sh8000_0000, 32'sh7fff_ffff));
		reg_write(REG_PLANE, 64'h0000_0000_7fff_ffff);
		reg_write(7, 64'hffff_ffff_ffff_ffff);
		random_pixels(40, 1'b1);
		drain();
		reg_write(REG_PLANE, 64'h0000_0000_8000_0000);
		random_pixels(40, 1'b1);
		drain();

		// random well-formed cameras near the pixel grid, with varied pressure
		for (int ph = 0; ph < 8; ph++) begin
			for (int i = 0; i < 6; i++) begin
				if (ph == 7 || $urandom_range(0, 4) == 0)
					v = {$urandom, $urandom};
				else
					v = xy($signed($urandom_range(0, 50 << 16)) - (5 <<< 16),
						$signed($urandom_range(0, 50 << 16)) - (5 <<< 16));
				reg_write(i, v);
			end
			reg_write(REG_PLANE, (ph % 3 == 0) ? 64'(32'sd65536)
				: 64'($signed($urandom_range(0, 8 << 16)) - (4 <<< 16)));
			steady = (ph == 2);
			if (ph == 4) hold_off = 1'b1;
			random_pixels(75, 1'b0);
			drain();
			steady = 1'b0;
		end

		// degenerate: all points on one line
		reg_write(REG_RAY0_ORG, xy(32'sd65536, 32'sd65536));
		reg_write(REG_RAY1_ORG, xy(32'sd131072, 32'sd131072));
		reg_write(REG_RAY2_ORG, xy(32'sd196608, 32'sd196608));
		reg_write(REG_RAY0_DIR, 0);
		reg_write(REG_RAY1_DIR, 0);
		reg_write(REG_RAY2_DIR, 0);
		random_pixels(20, 1'b1);
		drain();

		if (errors == 0) begin
			$display("[linear_camera_ray_generator_top] OK");
		end else begin
			$display("[linear_camera_ray_generator_top] ERROR");
		end
		$finish;
	end
endmodule
